[design/udp_frame_word_builder_top_macros.svh]
// ----------------------------------------------------------------------------
// udp_frame_word_builder_top_macros.svh
// Assertion macros used by the checker file of the frame word builder.
// ----------------------------------------------------------------------------
`ifndef UDP_FRAME_WORD_BUILDER_TOP_MACROS_SVH
`define UDP_FRAME_WORD_BUILDER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define UFWB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define UFWB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ufwb_pkg.sv]
// ----------------------------------------------------------------------------
// ufwb_pkg
// Types and constants shared by the UDP frame word builder.
// ----------------------------------------------------------------------------
package ufwb_pkg;

  // Frame geometry.
  localparam int MAX_FRAME_BYTES = 9000;
  localparam int BYTES_PER_WORD  = 8;
  localparam int FLEN_W          = 14;
  localparam int HDR_MAX_BYTES   = 46;
  localparam int HDR_BASE_BYTES  = 42;
  localparam int HDR_IDX_W       = $clog2(HDR_MAX_BYTES);
  localparam int WORD_BITS       = 8 * BYTES_PER_WORD;
  localparam int VB_W            = 4;

  // Protocol constants.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETHERTYPE_VLAN = 16'h8100;
  localparam logic [15:0] VLAN_TCI_MASK  = 16'hEFFF;
  localparam logic [7:0]  IP_VER_IHL     = 8'h45;
  localparam logic [7:0]  IP_TTL         = 8'd64;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
  localparam logic [15:0] IP_UDP_HDR_LEN = 16'd28;
  localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
  localparam int          PORT_MODULUS   = 1000;

  // Register reset values.
  localparam logic [31:0] PORT_PAIR_RESET   = 32'h2710_1389;
  localparam logic [13:0] FRAME_BYTES_RESET = 14'd1472;

  // Configuration port geometry: 64-bit registers at 8-byte spacing.
  localparam int NUM_REGS = 8;
  localparam int PADDR_W  = $clog2(NUM_REGS) + 3;

  typedef enum logic [2:0] {
    REG_DEST_MAC    = 3'd0,
    REG_SOURCE_MAC  = 3'd1,
    REG_SOURCE_IPV4 = 3'd2,
    REG_DEST_IPV4   = 3'd3,
    REG_PORT_PAIR   = 3'd4,
    REG_FRAME_BYTES = 3'd5,
    REG_VLAN_TAG    = 3'd6,
    REG_DSCP_VALUE  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [47:0]       dest_mac;
    logic [47:0]       source_mac;
    logic [31:0]       source_ipv4;
    logic [31:0]       dest_ipv4;
    logic [31:0]       port_pair;
    logic [FLEN_W-1:0] frame_bytes;
    logic [15:0]       vlan_tag;
    logic [5:0]        dscp_value;
  } cfg_t;

  typedef logic [0:HDR_MAX_BYTES-1][7:0] hdr_bytes_t;

endpackage

[design/ufwb_cfg.sv]
// ----------------------------------------------------------------------------
// ufwb_cfg
// APB register file holding the frame configuration.
// ----------------------------------------------------------------------------
module ufwb_cfg
  import ufwb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes complete in the access phase of a write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_mac    <= '0;
      cfg.source_mac  <= '0;
      cfg.source_ipv4 <= '0;
      cfg.dest_ipv4   <= '0;
      cfg.port_pair   <= PORT_PAIR_RESET;
      cfg.frame_bytes <= FRAME_BYTES_RESET;
      cfg.vlan_tag    <= '0;
      cfg.dscp_value  <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DEST_MAC:    cfg.dest_mac    <= pwdata[47:0];
        REG_SOURCE_MAC:  cfg.source_mac  <= pwdata[47:0];
        REG_SOURCE_IPV4: cfg.source_ipv4 <= pwdata[31:0];
        REG_DEST_IPV4:   cfg.dest_ipv4   <= pwdata[31:0];
        REG_PORT_PAIR:   cfg.port_pair   <= pwdata[31:0];
        REG_FRAME_BYTES: cfg.frame_bytes <= pwdata[FLEN_W-1:0];
        REG_VLAN_TAG:    cfg.vlan_tag    <= pwdata[15:0];
        REG_DSCP_VALUE:  cfg.dscp_value  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Read data is the addressed register, zero-extended.
  always_comb begin
    case (reg_sel)
      REG_DEST_MAC:    prdata = 64'(cfg.dest_mac);
      REG_SOURCE_MAC:  prdata = 64'(cfg.source_mac);
      REG_SOURCE_IPV4: prdata = 64'(cfg.source_ipv4);
      REG_DEST_IPV4:   prdata = 64'(cfg.dest_ipv4);
      REG_PORT_PAIR:   prdata = 64'(cfg.port_pair);
      REG_FRAME_BYTES: prdata = 64'(cfg.frame_bytes);
      REG_VLAN_TAG:    prdata = 64'(cfg.vlan_tag);
      REG_DSCP_VALUE:  prdata = 64'(cfg.dscp_value);
      default:         prdata = '0;
    endcase
  end

endmodule

[design/ufwb_hdr.sv]
// ----------------------------------------------------------------------------
// ufwb_hdr
// Builds the Ethernet, optional VLAN, IPv4 and UDP header bytes of a flow.
// ----------------------------------------------------------------------------
module ufwb_hdr
  import ufwb_pkg::*;
(
  input  cfg_t                 cfg,
  input  logic [15:0]          flow_number,
  input  logic [FLEN_W-1:0]    flen,
  output hdr_bytes_t           hdr,
  output logic [HDR_IDX_W-1:0] hdr_len
);

  logic              vlan_on;
  logic [FLEN_W-1:0] pay_len;
  logic [15:0]       ip_len;
  logic [15:0]       udp_len;
  logic [7:0]        tos;
  logic [19:0]       csum_sum;
  logic [16:0]       csum_fold;
  logic [15:0]       csum_final;
  logic [15:0]       ip_csum;
  logic [11:0]       mod_sum;
  logic [9:0]        flow_mod;
  logic [15:0]       udp_sport;
  logic [159:0]      ip_hdr;
  logic [63:0]       udp_hdr;

  // The tag goes in only when its VLAN id is nonzero.
  assign vlan_on = |cfg.vlan_tag[11:0];
  assign hdr_len = vlan_on ? HDR_IDX_W'(HDR_MAX_BYTES) : HDR_IDX_W'(HDR_BASE_BYTES);

  // Payload length; a frame too short for the headers carries none.
  assign pay_len = (flen > FLEN_W'(hdr_len)) ? flen - FLEN_W'(hdr_len) : '0;
  assign ip_len  = 16'(pay_len) + IP_UDP_HDR_LEN;
  assign udp_len = 16'(pay_len) + UDP_HDR_LEN;
  assign tos     = {cfg.dscp_value, 2'b00};

  // IPv4 header checksum: add the nonzero halfwords, fold twice, invert.
  assign csum_sum = 20'({IP_VER_IHL, tos}) + 20'(ip_len) + 20'(flow_number)
                  + 20'({IP_TTL, IP_PROTO_UDP})
                  + 20'(cfg.source_ipv4[31:16]) + 20'(cfg.source_ipv4[15:0])
                  + 20'(cfg.dest_ipv4[31:16]) + 20'(cfg.dest_ipv4[15:0]);
  assign csum_fold  = 17'(csum_sum[15:0]) + 17'(csum_sum[19:16]);
  assign csum_final = csum_fold[15:0] + 16'(csum_fold[16]);
  assign ip_csum    = ~csum_final;

  // Flow number mod 1000: 1024 is 24 more than 1000, so the upper six bits
  // fold in as times 24; the sum stays below 3000 and needs two corrections.
  assign mod_sum = 12'({flow_number[15:10], 4'b0000}) + 12'({flow_number[15:10], 3'b000})
                 + 12'(flow_number[9:0]);
  always_comb begin
    if (mod_sum >= 12'(2 * PORT_MODULUS)) begin
      flow_mod = 10'(mod_sum - 12'(2 * PORT_MODULUS));
    end else if (mod_sum >= 12'(PORT_MODULUS)) begin
      flow_mod = 10'(mod_sum - 12'(PORT_MODULUS));
    end else begin
      flow_mod = 10'(mod_sum);
    end
  end
  assign udp_sport = cfg.port_pair[31:16] + 16'(flow_mod);

  assign ip_hdr  = {IP_VER_IHL, tos, ip_len, flow_number, 16'h0000,
                    IP_TTL, IP_PROTO_UDP, ip_csum, cfg.source_ipv4, cfg.dest_ipv4};
  assign udp_hdr = {udp_sport, cfg.port_pair[15:0], udp_len, 16'h0000};

  // Header bytes in send order; the untagged layout leaves four spare bytes.
  always_comb begin
    if (vlan_on) begin
      hdr = {cfg.dest_mac, cfg.source_mac, ETHERTYPE_VLAN,
             cfg.vlan_tag & VLAN_TCI_MASK, ETHERTYPE_IPV4, ip_hdr, udp_hdr};
    end else begin
      hdr = {cfg.dest_mac, cfg.source_mac, ETHERTYPE_IPV4, ip_hdr, udp_hdr, 32'h0};
    end
  end

endmodule

[design/udp_frame_word_builder_top.sv]
// ----------------------------------------------------------------------------
// udp_frame_word_builder_top
// Produces one 8-byte word of an Ethernet/IPv4/UDP test frame per transfer.
// ----------------------------------------------------------------------------
// The block takes one (flow_number, word_index) transfer per clock and returns
// one word per clock while not stalled: the request is captured in an input
// register, the headers, checksum and byte selection are computed in a single
// combinational pass, and the word lands in the result register. The result
// register stalls on result_ready and the input register keeps accepting as
// long as its contents can move on. Configuration is written through the APB
// port at byte address 8*i and must not change while words are in flight.
module udp_frame_word_builder_top
  import ufwb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // APB configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  // Request channel
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [15:0]          flow_number,
  input  logic [10:0]          word_index,
  // Result channel
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [WORD_BITS-1:0] word_data,
  output logic [VB_W-1:0]      valid_bytes,
  output logic                 last_word
);

  cfg_t                 cfg;
  hdr_bytes_t           hdr;
  logic [HDR_IDX_W-1:0] hdr_len;

  logic                 s1_valid;
  logic [15:0]          s1_flow;
  logic [10:0]          s1_widx;
  logic                 advance;

  logic [FLEN_W-1:0]    flen;
  logic [FLEN_W-1:0]    start;
  logic [FLEN_W-1:0]    remain;
  logic                 in_frame;
  logic [VB_W-1:0]      count_next;
  logic                 last_next;
  logic [WORD_BITS-1:0] data_next;

  ufwb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline control: the result register loads a held input request whenever it is free or drained.
  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      s1_flow <= flow_number;
      s1_widx <= word_index;
    end
  end

  // Frame length saturated to the largest supported frame.
  assign flen = (cfg.frame_bytes > FLEN_W'(MAX_FRAME_BYTES)) ?
                FLEN_W'(MAX_FRAME_BYTES) : cfg.frame_bytes;

  ufwb_hdr u_hdr (
    .cfg         (cfg),
    .flow_number (s1_flow),
    .flen        (flen),
    .hdr         (hdr),
    .hdr_len     (hdr_len)
  );

  // Word position within the frame and the number of bytes it holds.
  assign start    = {s1_widx, 3'b000};
  assign in_frame = start < flen;
  assign remain   = flen - start;
  always_comb begin
    if (!in_frame) begin
      count_next = '0;
    end else if (remain >= FLEN_W'(BYTES_PER_WORD)) begin
      count_next = VB_W'(BYTES_PER_WORD);
    end else begin
      count_next = remain[VB_W-1:0];
    end
  end
  assign last_next = in_frame && (remain <= FLEN_W'(BYTES_PER_WORD));

  // Each byte lane picks a header byte or a payload counter byte.
  always_comb begin
    logic [FLEN_W-1:0] pos;
    logic [FLEN_W-1:0] pay_off;
    data_next = '0;
    for (int k = 0; k < BYTES_PER_WORD; k++) begin
      pos     = start + FLEN_W'(k);
      pay_off = pos - FLEN_W'(hdr_len);
      if (VB_W'(k) < count_next) begin
        if (pos < FLEN_W'(hdr_len)) begin
          data_next[WORD_BITS-1-8*k -: 8] = hdr[pos[HDR_IDX_W-1:0]];
        end else begin
          data_next[WORD_BITS-1-8*k -: 8] = pay_off[7:0];
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      word_data   <= data_next;
      valid_bytes <= count_next;
      last_word   <= last_next;
    end
  end

endmodule

[design/ufwb_checker.sv]
// ----------------------------------------------------------------------------
// ufwb_checker
// Port-level checks on the result channel of the frame word builder.
// ----------------------------------------------------------------------------
`include "udp_frame_word_builder_top_macros.svh"

module ufwb_checker
  import ufwb_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 result_valid,
  input logic                 result_ready,
  input logic [WORD_BITS-1:0] word_data,
  input logic [VB_W-1:0]      valid_bytes,
  input logic                 last_word
);

  // A stalled result stays offered until its transfer.
  `UFWB_ASSERT_NEXT(a_hold_valid, result_valid && !result_ready, result_valid, "result dropped while stalled")

  // A word never claims more bytes than it carries.
  `UFWB_ASSERT_NOW(a_count_range, result_valid, valid_bytes <= VB_W'(BYTES_PER_WORD), "valid_bytes out of range")

  // A word past the frame end is empty and not last.
  `UFWB_ASSERT_NOW(a_past_end, result_valid && valid_bytes == '0, word_data == '0 && !last_word, "word past frame end not empty")

  // Only the final word of a frame may be partly filled.
  `UFWB_ASSERT_NOW(a_partial_last, result_valid && valid_bytes != '0 && valid_bytes != VB_W'(BYTES_PER_WORD), last_word, "partial word not marked last")

endmodule

bind udp_frame_word_builder_top ufwb_checker u_ufwb_checker (.*);
